FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// Depends on nothing; take it in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`endif

FILE: rtl/core/bmpalloc_pkg.sv
// Shared types and constants of the pool allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package bmpalloc_pkg;

  localparam int unsigned AddrBits   = 16;
  localparam int unsigned SizeBits   = 17;
  localparam int unsigned AlignBits  = 4;
  localparam int unsigned StatusBits = 3;

  // Size of the address space, also the largest usable pool.
  localparam logic [SizeBits-1:0] SpaceBytes = SizeBits'(64'd1 << AddrBits);
  localparam logic [SizeBits-1:0] PoolReset  = SizeBits'(64'd65536);

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  typedef enum logic [StatusBits-1:0] {
    StOk       = 3'd0,
    StOom      = 3'd1,
    StUnknown  = 3'd2,
    StMismatch = 3'd3,
    StFull     = 3'd4
  } status_e;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic scan;
    logic commit;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic hit;
    logic miss;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/core/bmpalloc_ctrl.sv
// Request sequencer of the pool allocator: idle, record scan, finish.
// Depends on bmpalloc_pkg for the command and status structs.
module bmpalloc_ctrl import bmpalloc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StScan   = 2'd1;
  localparam logic [1:0] StFinish = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StScan;
      end
      StScan: begin
        if (sts_i.hit || sts_i.miss) state_d = StFinish;
      end
      StFinish: begin
        // hold until the result register can take the result
        if (sts_i.out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o    = (state_q != StIdle);
  assign cmd_o.accept = (state_q == StIdle) && in_valid_i;
  assign cmd_o.scan   = (state_q == StScan);
  assign cmd_o.commit = (state_q == StFinish) && sts_i.out_free;

endmodule

FILE: rtl/core/bmpalloc_dp.sv
// Datapath of the pool allocator: record memory, scan pipeline, bump logic,
// counters and result register. Depends on bmpalloc_pkg.
module bmpalloc_dp import bmpalloc_pkg::*; #(
  parameter int unsigned MAX_RECORDS = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_wr_en_i,
  input  logic [SizeBits-1:0]                  cfg_wr_data_i,
  input  logic                                 operation_i,
  input  logic [SizeBits-1:0]                  request_bytes_i,
  input  logic [AlignBits-1:0]                 align_log2_i,
  input  logic [AddrBits-1:0]                  block_address_i,
  input  cmd_t                                 cmd_i,
  output sts_t                                 sts_o,
  input  logic                                 out_stall_i,
  output logic                                 out_valid_o,
  output logic [StatusBits-1:0]                status_o,
  output logic [AddrBits-1:0]                  granted_address_o,
  output logic [SizeBits-1:0]                  used_bytes_o,
  output logic [$clog2(MAX_RECORDS + 1)-1:0]   active_blocks_o,
  output logic [$clog2(MAX_RECORDS + 1)-1:0]   freed_blocks_o
);

  localparam int unsigned IdxW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int unsigned CntW = $clog2(MAX_RECORDS + 1);

  typedef struct packed {
    logic [AddrBits-1:0] offset;
    logic [SizeBits-1:0] size;
    logic                is_free;
  } rec_t;

  rec_t rec_mem_q [MAX_RECORDS];

  // configuration and request
  logic [SizeBits-1:0]  pool_q;
  logic                 op_q;
  logic [SizeBits-1:0]  bytes_q;
  logic [AlignBits-1:0] lg_q;
  logic [AddrBits-1:0]  addr_q;

  // allocator state
  logic [SizeBits-1:0]  bump_q, bump_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [CntW-1:0]      inuse_q, inuse_d;
  logic [CntW-1:0]      nfree_q, nfree_d;
  logic [AddrBits-1:0]  last_off_q, last_off_d;
  logic                 last_free_q, last_free_d;

  // scan pipeline
  logic [CntW-1:0]      issue_q;
  logic                 rd_vld_q;
  logic [IdxW-1:0]      rd_idx_q;
  rec_t                 rd_rec_q;
  logic                 hit_q;
  logic [IdxW-1:0]      hit_idx_q;
  rec_t                 hit_rec_q;
  logic [SizeBits-1:0]  aligned_q;

  // result register
  logic                 ovalid_q;
  status_e              status_q;
  logic [AddrBits-1:0]  grant_q;
  logic [SizeBits-1:0]  used_q;
  logic [CntW-1:0]      active_q;
  logic [CntW-1:0]      freed_q;

  logic                 rd_en;
  logic [AddrBits-1:0]  off_mask;
  logic                 alloc_fit;
  logic                 free_fit;
  logic                 scan_hit;
  logic [SizeBits:0]    align_m1;
  logic [SizeBits:0]    aligned_sum;
  logic [SizeBits-1:0]  pool_eff;
  logic [SizeBits:0]    end_c;
  logic                 oom;
  logic [CntW-1:0]      cnt_m1;
  logic [IdxW-1:0]      last_idx;
  logic                 replace;
  logic                 full;
  logic                 mem_we;
  logic [IdxW-1:0]      wr_idx;
  rec_t                 wr_rec;
  status_e              status_c;
  logic [AddrBits-1:0]  grant_c;

  // ---------------------------------------------------------------- scan
  assign rd_en    = cmd_i.scan && (issue_q < count_q);
  assign off_mask = ~({AddrBits{1'b1}} << lg_q);
  assign alloc_fit = rd_rec_q.is_free && (rd_rec_q.size >= bytes_q) &&
                     ((rd_rec_q.offset & off_mask) == '0);
  assign free_fit  = (rd_rec_q.offset == addr_q);
  assign scan_hit  = rd_vld_q && ((op_q == OpAlloc) ? alloc_fit : free_fit);

  assign sts_o.hit      = scan_hit;
  assign sts_o.miss     = !rd_vld_q && (issue_q >= count_q);
  assign sts_o.out_free = !ovalid_q || !out_stall_i;

  // round the bump pointer up to the alignment
  assign align_m1    = ~({(SizeBits + 1){1'b1}} << lg_q);
  assign aligned_sum = (({1'b0, bump_q} + align_m1) & ~align_m1);

  always_ff @(posedge clk_i) begin
    if (mem_we) rec_mem_q[wr_idx] <= wr_rec;
    if (rd_en) rd_rec_q <= rec_mem_q[issue_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q  <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
    end else if (cmd_i.accept) begin
      issue_q  <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
    end else if (cmd_i.scan) begin
      issue_q  <= issue_q + CntW'(rd_en);
      rd_vld_q <= rd_en;
      if (scan_hit) hit_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    aligned_q <= aligned_sum[SizeBits-1:0];
    if (rd_en) rd_idx_q <= issue_q[IdxW-1:0];
    if (cmd_i.scan && scan_hit) begin
      hit_idx_q <= rd_idx_q;
      hit_rec_q <= rd_rec_q;
    end
    if (cmd_i.accept) begin
      op_q    <= operation_i;
      bytes_q <= request_bytes_i;
      lg_q    <= align_log2_i;
      addr_q  <= block_address_i;
    end
  end

  // ---------------------------------------------------------------- finish
  assign pool_eff = (pool_q > SpaceBytes) ? SpaceBytes : pool_q;
  assign end_c    = {1'b0, aligned_q} + {1'b0, bytes_q};
  assign oom      = (aligned_q >= SpaceBytes) || (end_c > {1'b0, pool_eff});
  assign cnt_m1   = count_q - CntW'(1);
  assign last_idx = cnt_m1[IdxW-1:0];
  assign replace  = (count_q != '0) && (last_off_q == aligned_q[AddrBits-1:0]);
  assign full     = (count_q == CntW'(MAX_RECORDS));

  always_comb begin
    status_c    = StOk;
    grant_c     = '0;
    mem_we      = 1'b0;
    wr_idx      = hit_idx_q;
    wr_rec      = hit_rec_q;
    bump_d      = bump_q;
    count_d     = count_q;
    inuse_d     = inuse_q;
    nfree_d     = nfree_q;
    last_off_d  = last_off_q;
    last_free_d = last_free_q;
    if (op_q == OpAlloc) begin
      if (hit_q) begin
        // reuse a freed record, keep its size
        mem_we         = 1'b1;
        wr_rec.is_free = 1'b0;
        nfree_d        = nfree_q - CntW'(1);
        inuse_d        = inuse_q + CntW'(1);
        grant_c        = hit_rec_q.offset;
        if (hit_idx_q == last_idx) last_free_d = 1'b0;
      end else if (oom) begin
        status_c = StOom;
      end else if (replace || !full) begin
        mem_we         = 1'b1;
        wr_rec.offset  = aligned_q[AddrBits-1:0];
        wr_rec.size    = bytes_q;
        wr_rec.is_free = 1'b0;
        bump_d         = end_c[SizeBits-1:0];
        grant_c        = aligned_q[AddrBits-1:0];
        last_off_d     = aligned_q[AddrBits-1:0];
        last_free_d    = 1'b0;
        if (replace) begin
          // zero-size tail record at the same offset: overwrite it
          wr_idx = last_idx;
          if (last_free_q) begin
            nfree_d = nfree_q - CntW'(1);
            inuse_d = inuse_q + CntW'(1);
          end
        end else begin
          wr_idx  = count_q[IdxW-1:0];
          count_d = count_q + CntW'(1);
          inuse_d = inuse_q + CntW'(1);
        end
      end else begin
        status_c = StFull;
      end
    end else begin
      if (!hit_q) begin
        status_c = StUnknown;
      end else if (hit_rec_q.size != bytes_q) begin
        status_c = StMismatch;
      end else if (!hit_rec_q.is_free) begin
        mem_we         = 1'b1;
        wr_rec.is_free = 1'b1;
        inuse_d        = inuse_q - CntW'(1);
        nfree_d        = nfree_q + CntW'(1);
        if (hit_idx_q == last_idx) last_free_d = 1'b1;
      end
    end
    mem_we = mem_we && cmd_i.commit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q   <= PoolReset;
      bump_q   <= '0;
      count_q  <= '0;
      inuse_q  <= '0;
      nfree_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_wr_en_i) pool_q <= cfg_wr_data_i;
      if (cmd_i.commit) begin
        bump_q   <= bump_d;
        count_q  <= count_d;
        inuse_q  <= inuse_d;
        nfree_q  <= nfree_d;
        ovalid_q <= 1'b1;
      end else if (!out_stall_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      last_off_q  <= last_off_d;
      last_free_q <= last_free_d;
      status_q    <= status_c;
      grant_q     <= grant_c;
      used_q      <= bump_d;
      active_q    <= inuse_d;
      freed_q     <= nfree_d;
    end
  end

  assign out_valid_o       = ovalid_q;
  assign status_o          = status_q;
  assign granted_address_o = grant_q;
  assign used_bytes_o      = used_q;
  assign active_blocks_o   = active_q;
  assign freed_blocks_o    = freed_q;

endmodule

FILE: rtl/core/bump_allocator_with_block_reuse_core.sv
// Channel   Handshake               Payload
// request   in_valid_i/in_stall_o   operation, request_bytes, align_log2, block_address
// result    out_valid_o/out_stall_i status, granted_address, used_bytes, active/freed
// config    cfg_wr_en_i             cfg_wr_data_i (pool_bytes)
//
// A request is accepted, then the record memory is read one record per cycle
// over the table; after the read latency and a check for the end of the table
// the result is committed. A hit ends the scan early. The single memory read
// port sets the scan rate. Reset needs no clearing pass; counters clear at once.
// A stalled result holds the request in the finish state until the output
// register is taken.
`include "assert_macros.svh"

module bump_allocator_with_block_reuse_core import bmpalloc_pkg::*; #(
  parameter int unsigned MAX_RECORDS = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_wr_en_i,
  input  logic [SizeBits-1:0]                cfg_wr_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               operation_i,
  input  logic [SizeBits-1:0]                request_bytes_i,
  input  logic [AlignBits-1:0]               align_log2_i,
  input  logic [AddrBits-1:0]                block_address_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [StatusBits-1:0]              status_o,
  output logic [AddrBits-1:0]                granted_address_o,
  output logic [SizeBits-1:0]                used_bytes_o,
  output logic [$clog2(MAX_RECORDS + 1)-1:0] active_blocks_o,
  output logic [$clog2(MAX_RECORDS + 1)-1:0] freed_blocks_o
);

  cmd_t ctl_cmd;
  sts_t dp_sts;

  bmpalloc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (dp_sts),
    .cmd_o      (ctl_cmd)
  );

  bmpalloc_dp #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_wr_en_i       (cfg_wr_en_i),
    .cfg_wr_data_i     (cfg_wr_data_i),
    .operation_i       (operation_i),
    .request_bytes_i   (request_bytes_i),
    .align_log2_i      (align_log2_i),
    .block_address_i   (block_address_i),
    .cmd_i             (ctl_cmd),
    .sts_o             (dp_sts),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .status_o          (status_o),
    .granted_address_o (granted_address_o),
    .used_bytes_o      (used_bytes_o),
    .active_blocks_o   (active_blocks_o),
    .freed_blocks_o    (freed_blocks_o)
  );

  `ASSERT_ALWAYS(a_one_cmd, clk_i, rst_ni, $onehot0(ctl_cmd), "more than one command issued")
  `ASSERT_IMPLIES(a_commit_room, clk_i, rst_ni, ctl_cmd.commit, dp_sts.out_free, "lost result")
  `ASSERT_NEXT(a_commit_shows, clk_i, rst_ni, ctl_cmd.commit, out_valid_o, "commit without result")
  `ASSERT_NEXT(a_commit_idle, clk_i, rst_ni, ctl_cmd.commit, !in_stall_o, "stuck after commit")

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the pool allocator core: random and directed requests,
// each result compared against an in-bench model of the record table and bump pointer.
// Depends on bmpalloc_pkg and bump_allocator_with_block_reuse_core.
module tb_top;
  import bmpalloc_pkg::*;

  localparam int MaxRecords = 64;
  localparam int CountBits  = $clog2(MaxRecords + 1);
  localparam int StallLimit = 4000;
  localparam int PhaseItems = 172;

  typedef struct packed {
    status_e                status;
    logic [AddrBits-1:0]    addr;
    logic [SizeBits-1:0]    used;
    logic [CountBits-1:0]   active;
    logic [CountBits-1:0]   freed;
  } reply_t;

  class pool_scoreboard;
    logic [AddrBits-1:0] rec_off [MaxRecords];
    logic [SizeBits-1:0] rec_size [MaxRecords];
    bit                  rec_free [MaxRecords];
    int                  rec_cnt;
    int                  busy_cnt;
    int                  free_cnt;
    longint unsigned     bump;
    longint unsigned     pool;
    reply_t              replies_due [$];
    int                  errors;

    function new();
      pool = PoolReset;
    endfunction

    // Advance the table by one request and return the reply it must produce.
    function reply_t serve(logic op, logic [SizeBits-1:0] bytes, logic [AlignBits-1:0] lg,
                           logic [AddrBits-1:0] addr);
      reply_t          r;
      longint unsigned align;
      longint unsigned limit;
      longint unsigned aligned;
      int              slot;
      bit              done;
      r = '0;
      r.status = StOk;
      done = 0;
      slot = -1;
      if (op == OpAlloc) begin
        align = 64'd1 << lg;
        // first fit over freed records, lowest offset first
        for (int i = 0; i < rec_cnt && !done; i++) begin
          if (rec_free[i] && rec_size[i] >= bytes && (rec_off[i] & (align - 1)) == 0) begin
            rec_free[i] = 0;
            free_cnt--;
            busy_cnt++;
            r.addr = rec_off[i];
            done = 1;
          end
        end
        if (!done) begin
          limit = (pool > SpaceBytes) ? SpaceBytes : pool;
          aligned = (bump + align - 1) & ~(align - 1);
          if (aligned >= SpaceBytes || aligned + bytes > limit) begin
            r.status = StOom;
          end else if (rec_cnt > 0 && rec_off[rec_cnt-1] == aligned) begin
            // zero-size tail record at the same offset: take it over
            slot = rec_cnt - 1;
            if (rec_free[slot]) free_cnt--;
            else busy_cnt--;
          end else if (rec_cnt >= MaxRecords) begin
            r.status = StFull;
          end else begin
            slot = rec_cnt;
            rec_cnt++;
          end
          if (slot >= 0) begin
            rec_off[slot] = aligned[AddrBits-1:0];
            rec_size[slot] = bytes;
            rec_free[slot] = 0;
            busy_cnt++;
            bump = aligned + bytes;
            r.addr = aligned[AddrBits-1:0];
          end
        end
      end else begin
        r.status = StUnknown;
        for (int i = 0; i < rec_cnt && !done; i++) begin
          if (rec_off[i] == addr) begin
            done = 1;
            if (rec_size[i] != bytes) begin
              r.status = StMismatch;
            end else begin
              r.status = StOk;
              if (!rec_free[i]) begin
                rec_free[i] = 1;
                busy_cnt--;
                free_cnt++;
              end
            end
          end
        end
      end
      r.used = bump[SizeBits-1:0];
      r.active = busy_cnt[CountBits-1:0];
      r.freed = free_cnt[CountBits-1:0];
      return r;
    endfunction

    function void note_request(logic op, logic [SizeBits-1:0] bytes,
                               logic [AlignBits-1:0] lg, logic [AddrBits-1:0] addr);
      replies_due.push_back(serve(op, bytes, lg, addr));
    endfunction

    function void compare_field(string label, longint unsigned want, longint unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected %0h actual %0h", $time, label, want, got);
      end
    endfunction

    function void check_result(reply_t got);
      reply_t want;
      if (replies_due.size() == 0) begin
        errors++;
        $display("%0t: result status %0h with no request pending expected none actual %0h",
                 $time, got.status, got.addr);
        return;
      end
      want = replies_due.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("granted_address", want.addr, got.addr);
      compare_field("used_bytes", want.used, got.used);
      compare_field("active_blocks", want.active, got.active);
      compare_field("freed_blocks", want.freed, got.freed);
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_wr_en_i;
  logic [SizeBits-1:0]   cfg_wr_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  operation_i;
  logic [SizeBits-1:0]   request_bytes_i;
  logic [AlignBits-1:0]  align_log2_i;
  logic [AddrBits-1:0]   block_address_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [StatusBits-1:0] status_o;
  logic [AddrBits-1:0]   granted_address_o;
  logic [SizeBits-1:0]   used_bytes_o;
  logic [CountBits-1:0]  active_blocks_o;
  logic [CountBits-1:0]  freed_blocks_o;

  pool_scoreboard sb = new();
  int src_max;
  int sink_max;
  int stall_left;
  reply_t seen;

  bump_allocator_with_block_reuse_core #(
    .MAX_RECORDS(MaxRecords)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_wr_en_i      (cfg_wr_en_i),
    .cfg_wr_data_i    (cfg_wr_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .request_bytes_i  (request_bytes_i),
    .align_log2_i     (align_log2_i),
    .block_address_i  (block_address_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .granted_address_o(granted_address_o),
    .used_bytes_o     (used_bytes_o),
    .active_blocks_o  (active_blocks_o),
    .freed_blocks_o   (freed_blocks_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hold the result channel for a random count of cycles after each taken result.
  initial begin
    out_stall_i = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        sb.note_request(operation_i, request_bytes_i, align_log2_i, block_address_i);
      if (out_valid_o && !out_stall_i) begin
        seen.status = status_e'(status_o);
        seen.addr = granted_address_o;
        seen.used = used_bytes_o;
        seen.active = active_blocks_o;
        seen.freed = freed_blocks_o;
        sb.check_result(seen);
        stall_left = $urandom_range(0, sink_max);
      end
    end
  end

  // End the run when neither channel moves for too long.
  initial begin
    int stuck;
    stuck = 0;
    while (stuck < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck = 0;
      else stuck++;
    end
    $display("tb_top: errors");
    $finish;
  end

  task automatic issue(input logic op, input logic [SizeBits-1:0] bytes,
                       input logic [AlignBits-1:0] lg, input logic [AddrBits-1:0] addr);
    int gap;
    gap = $urandom_range(0, src_max);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    operation_i <= op;
    request_bytes_i <= bytes;
    align_log2_i <= lg;
    block_address_i <= addr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Drop the request line, drain every result, then write the pool size.
  task automatic write_pool(input logic [SizeBits-1:0] value);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.replies_due.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_wr_en_i <= 1'b1;
    cfg_wr_data_i <= value;
    @(negedge clk_i);
    cfg_wr_en_i <= 1'b0;
    sb.pool = value;
  endtask

  task automatic random_request(input bit tiny);
    int                   pick;
    int                   sel;
    int                   idx;
    logic [SizeBits-1:0]  bytes;
    logic [AlignBits-1:0] lg;
    logic [AddrBits-1:0]  addr;
    pick = $urandom_range(0, 99);
    sel = $urandom_range(0, 99);
    lg = (sel < 70) ? AlignBits'($urandom_range(0, 4)) :
         (sel < 95) ? AlignBits'($urandom_range(5, 12)) : AlignBits'($urandom_range(13, 15));
    addr = AddrBits'($urandom_range(0, 65535));
    sel = $urandom_range(0, 99);
    if (tiny)          bytes = SizeBits'($urandom_range(0, 64));
    else if (sel < 10) bytes = '0;
    else if (sel < 70) bytes = SizeBits'($urandom_range(1, 64));
    else if (sel < 90) bytes = SizeBits'($urandom_range(65, 4096));
    else if (sel < 97) bytes = SizeBits'($urandom_range(4097, 65536));
    else               bytes = SizeBits'($urandom_range(0, 131071));
    if (pick < 55 || sb.rec_cnt == 0) begin
      issue(OpAlloc, bytes, lg, addr);
    end else begin
      idx = $urandom_range(0, sb.rec_cnt - 1);
      if (pick < 82)
        issue(OpFree, sb.rec_size[idx], lg, sb.rec_off[idx]);
      else if (pick < 90)
        issue(OpFree, sb.rec_size[idx] ^ (17'd1 << $urandom_range(0, 16)), lg, sb.rec_off[idx]);
      else
        issue(OpFree, bytes, lg, addr);
    end
  endtask

  initial begin
    logic [SizeBits-1:0] setting;
    cfg_wr_en_i = 1'b0;
    cfg_wr_data_i = '0;
    in_valid_i = 1'b0;
    operation_i = OpAlloc;
    request_bytes_i = '0;
    align_log2_i = '0;
    block_address_i = '0;
    rst_ni = 1'b0;
    src_max = 3;
    sink_max = 3;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_pool(PoolReset);
    issue(OpAlloc, 17'd0, 4'd0, 16'hFFFF);
    issue(OpAlloc, 17'd0, 4'd0, 16'h0000);    // replaces the zero-size tail record
    issue(OpAlloc, 17'd16, 4'd0, 16'h5555);
    issue(OpAlloc, 17'd100, 4'd4, 16'hAAAA);
    issue(OpFree, 17'd99, 4'd0, 16'd16);       // wrong size
    issue(OpFree, 17'd100, 4'd0, 16'd16);
    issue(OpFree, 17'd100, 4'd15, 16'd16);     // already free
    issue(OpFree, 17'd0, 4'd0, 16'hFFFF);      // unknown block
    issue(OpAlloc, 17'd50, 4'd3, 16'h0000);    // reuse at 16
    issue(OpAlloc, 17'd65536, 4'd0, 16'h0000);
    issue(OpAlloc, 17'd1, 4'd15, 16'hFFFF);
    issue(OpAlloc, 17'd0, 4'd15, 16'h0000);    // aligned offset past the address space
    issue(OpAlloc, 17'd1, 4'd12, 16'h0000);
    issue(OpFree, 17'd1, 4'd0, 16'h8000);
    issue(OpAlloc, 17'd1, 4'd13, 16'h0000);
    issue(OpFree, 17'd65536, 4'd7, 16'hAAAA);
    write_pool('0);                            // shrink below the bump pointer
    issue(OpAlloc, 17'd0, 4'd0, 16'h0000);
    issue(OpFree, 17'd50, 4'd0, 16'd16);
    issue(OpAlloc, 17'd8, 4'd2, 16'h0000);
    write_pool(17'h1FFFF);
    issue(OpAlloc, 17'd64, 4'd6, 16'h0000);
    issue(OpAlloc, 17'd4096, 4'd14, 16'h0000);
    issue(OpAlloc, 17'd0, 4'd14, 16'h0000);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          setting = PoolReset;
        end
        1: begin
          setting = 17'h1FFFF;
        end
        2: begin
          setting = '0;
        end
        3: begin
          setting = (sb.bump > 0) ? SizeBits'($urandom_range(0, int'(sb.bump) - 1)) : '0;
        end
        4: begin
          setting = SizeBits'($urandom_range(0, 65536));
        end
        default: begin
          setting = PoolReset;
        end
      endcase
      write_pool(setting);
      src_max = (phase == 1 || phase == 5) ? 0 : 3;
      sink_max = (phase == 1 || phase == 4) ? 0 : 3;
      // keep sizes small in phases 0 and 4 so the record table fills before the pool does
      for (int n = 0; n < PhaseItems; n++)
        random_request(phase == 0 || phase == 4);
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.replies_due.size() != 0) @(posedge clk_i);
    repeat (MaxRecords + 8) @(posedge clk_i);
    if (sb.errors == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
